### hw/rtl/ema_zscore_normalizer_defines.svh
// ============================================================================
// ema_zscore_normalizer_defines.svh
// Assertion macros used by the normalizer controller.
// ============================================================================
`ifndef EMA_ZSCORE_NORMALIZER_DEFINES_SVH
`define EMA_ZSCORE_NORMALIZER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define EZN_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define EZN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ezn_pkg.sv
// ============================================================================
// ezn_pkg
// Types, constants and codes of the moving mean / variance z-score normalizer.
// ============================================================================
package ezn_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int ALPHA_W     = 17;
    localparam int ALPHA_FRAC  = 16;
    localparam int MEAN_FRAC   = 16;
    localparam int ACC_W       = 32;
    localparam int VAR_W       = 48;
    localparam int Z_FRAC      = 12;
    localparam int OUT_W       = 16;
    localparam int TSTD_W      = 15;
    localparam int SVAR_W      = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int SQRT_STEPS  = 16;  // two root bits per cycle
    localparam int DIV_STEPS   = 17;  // one quotient bit per cycle
    localparam int CNT_W       = 5;

    localparam logic [ALPHA_W-1:0]    ALPHA_ONE   = 17'd65536;
    localparam logic [ALPHA_W-1:0]    ALPHA_RESET = 17'd6554;
    localparam logic [OUT_W-1:0]      TMEAN_RESET = 16'd16384;
    localparam logic [TSTD_W-1:0]     TSTD_RESET  = 15'd8192;
    localparam logic [SAMPLE_W-1:0]   SMEAN_RESET = 16'd0;
    localparam logic [SVAR_W-1:0]     SVAR_RESET  = 32'd0;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_RESTART = 2'd1,
        OP_PRELOAD = 2'd2
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ALPHA = 3'd0,
        CFG_TMEAN = 3'd1,
        CFG_TSTD  = 3'd2,
        CFG_SMEAN = 3'd3,
        CFG_SVAR  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [ALPHA_W-1:0]         smoothing_alpha;
        logic signed [OUT_W-1:0]    target_mean;
        logic [TSTD_W-1:0]          target_stddev;
        logic signed [SAMPLE_W-1:0] start_mean;
        logic [SVAR_W-1:0]          start_variance;
    } cfg_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MEAN_MUL,
        CMD_MEAN_UPD,
        CMD_SQ_MUL,
        CMD_VAR_DIFF,
        CMD_VLO_MUL,
        CMD_VHI_MUL,
        CMD_VAR_UPD,
        CMD_SQRT_INIT,
        CMD_SQRT_STEP,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_SCALE,
        CMD_FINISH
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN_MUL,
        ST_MEAN_UPD,
        ST_SQ_MUL,
        ST_VAR_DIFF,
        ST_VLO_MUL,
        ST_VHI_MUL,
        ST_VAR_UPD,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_SCALE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic started;
    } dp_status_t;

endpackage

### hw/rtl/ezn_if.sv
// ============================================================================
// ezn_if
// Valid/ready stream interfaces for samples and results.
// ============================================================================
interface ezn_in_if;
    import ezn_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 opcode;
    logic signed [SAMPLE_W-1:0] sample;
    modport source (output valid, output opcode, output sample, input ready);
    modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface ezn_out_if;
    import ezn_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] scaled_value;
    logic signed [OUT_W-1:0] z_score;
    logic signed [OUT_W-1:0] running_mean;
    modport source (output valid, output scaled_value, output z_score,
                    output running_mean, input ready);
    modport sink   (input valid, input scaled_value, input z_score,
                    input running_mean, output ready);
endinterface

### hw/rtl/ezn_cfg_regs.sv
// ============================================================================
// ezn_cfg_regs
// Configuration register file, written through a plain write port.
// ============================================================================
module ezn_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ezn_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ezn_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ezn_pkg::cfg_t                   cfg
);
    import ezn_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoothing_alpha <= ALPHA_RESET;
            cfg_reg.target_mean     <= TMEAN_RESET;
            cfg_reg.target_stddev   <= TSTD_RESET;
            cfg_reg.start_mean      <= SMEAN_RESET;
            cfg_reg.start_variance  <= SVAR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALPHA: cfg_reg.smoothing_alpha <= cfg_data[ALPHA_W-1:0];
                CFG_TMEAN: cfg_reg.target_mean     <= cfg_data[OUT_W-1:0];
                CFG_TSTD:  cfg_reg.target_stddev   <= cfg_data[TSTD_W-1:0];
                CFG_SMEAN: cfg_reg.start_mean      <= cfg_data[SAMPLE_W-1:0];
                CFG_SVAR:  cfg_reg.start_variance  <= cfg_data[SVAR_W-1:0];
                default:   ;  // drop writes beyond the register list
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/ezn_datapath.sv
// ============================================================================
// ezn_datapath
// Mean/variance accumulators, shared multiplier, root and divider iterations.
// ============================================================================
module ezn_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ezn_pkg::cmd_t                     cmd,
    input  ezn_pkg::cfg_t                     cfg,
    input  logic [1:0]                        in_opcode,
    input  logic signed [ezn_pkg::SAMPLE_W-1:0] in_sample,
    output ezn_pkg::dp_status_t               status,
    output logic signed [ezn_pkg::OUT_W-1:0]  scaled_value,
    output logic signed [ezn_pkg::OUT_W-1:0]  z_score,
    output logic signed [ezn_pkg::OUT_W-1:0]  running_mean
);
    import ezn_pkg::*;

    // one restoring square-root step: {remainder, root}
    function automatic logic [66:0] sqrt_step(input logic [34:0] rem,
                                              input logic [31:0] root,
                                              input logic [1:0]  pair);
        logic [34:0] r;
        logic [34:0] trial;
        logic [31:0] rt;
        r     = {rem[32:0], pair};
        trial = {1'b0, root, 2'b01};
        if (r >= trial)
        begin
            r  = r - trial;
            rt = {root[30:0], 1'b1};
        end
        else
        begin
            rt = {root[30:0], 1'b0};
        end
        return {r, rt};
    endfunction

    function automatic logic signed [OUT_W-1:0] sat16(input logic signed [20:0] v);
        logic signed [20:0] hi;
        logic signed [20:0] lo;
        hi = 21'sd32767;
        lo = -21'sd32768;
        if (v > hi)
            return 16'sh7FFF;
        else if (v < lo)
            return 16'sh8000;
        else
            return v[OUT_W-1:0];
    endfunction

    // state
    logic signed [ACC_W-1:0]    mean_reg;
    logic [VAR_W-1:0]           var_reg;
    logic                       started_reg;
    // working registers
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       eneg_reg;
    logic [63:0]                prod_reg;
    logic [VAR_W-1:0]           diff_reg;
    logic                       vneg_reg;
    logic [40:0]                lo_reg;
    logic signed [32:0]         d_reg;
    logic [63:0]                n_reg;
    logic [34:0]                srem_reg;
    logic [31:0]                root_reg;
    logic [44:0]                drem_reg;
    logic [47:0]                dv_reg;
    logic [16:0]                q_reg;
    logic                       ovf_reg;
    logic signed [OUT_W-1:0]    z_reg;
    logic signed [OUT_W-1:0]    scaled_reg;
    logic signed [OUT_W-1:0]    zout_reg;
    logic signed [OUT_W-1:0]    mout_reg;

    logic [ALPHA_W-1:0]  alpha_a;
    logic signed [ACC_W-1:0] x_full;
    logic signed [32:0]  e_c;
    logic [32:0]         e_mag;
    logic signed [32:0]  dn_c;
    logic [32:0]         dn_mag;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic                mul_en;
    logic [32:0]         m_inc;
    logic [63:0]         sq_full;
    logic [VAR_W-1:0]    sq_c;
    logic [65:0]         vt_c;
    logic [VAR_W-1:0]    v_inc;
    logic [66:0]         s1_c;
    logic [66:0]         s2_c;
    logic [32:0]         dm_c;
    logic [44:0]         dnum_c;
    logic                dge_c;
    logic [17:0]         qr_c;
    logic [OUT_W-1:0]    qc_c;
    logic signed [OUT_W-1:0] z_c;
    logic [OUT_W-1:0]    zmag_c;
    logic [18:0]         sc_mag;
    logic signed [20:0]  sc_c;
    logic [32:0]         mm_c;
    logic [32:0]         mr_c;
    logic signed [20:0]  rm_c;

    assign alpha_a = (cfg.smoothing_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.smoothing_alpha;
    assign x_full  = {x_reg, {MEAN_FRAC{1'b0}}};

    assign e_c    = {mean_reg[ACC_W-1], mean_reg} - {x_full[ACC_W-1], x_full};
    assign e_mag  = e_c[32] ? 33'(-e_c) : 33'(e_c);
    assign dn_c   = {x_full[ACC_W-1], x_full} - {mean_reg[ACC_W-1], mean_reg};
    assign dn_mag = dn_c[32] ? 33'(-dn_c) : 33'(dn_c);

    assign m_inc  = 33'((prod_reg[48:0] + 49'h8000) >> ALPHA_FRAC);
    assign sq_full = (prod_reg + 64'h8000) >> MEAN_FRAC;
    assign sq_c   = sq_full[VAR_W-1:0];
    assign vt_c   = {1'b0, prod_reg[40:0], 24'b0} + {25'b0, lo_reg} + 66'h8000;
    assign v_inc  = vt_c[VAR_W+ALPHA_FRAC-1:ALPHA_FRAC];

    assign s1_c = sqrt_step(srem_reg, root_reg, n_reg[63:62]);
    assign s2_c = sqrt_step(s1_c[66:32], s1_c[31:0], n_reg[61:60]);

    assign dm_c   = d_reg[32] ? 33'(-d_reg) : 33'(d_reg);
    assign dnum_c = {dm_c[31:0], 13'b0};
    assign dge_c  = {3'b0, drem_reg} >= dv_reg;

    // z from the rounded quotient; saturate by sign on zero spread
    always_comb
    begin
        qr_c = ({1'b0, q_reg} + 18'd1) >> 1;
        if (ovf_reg || qr_c > 18'd32768)
            qc_c = 16'h8000;
        else
            qc_c = qr_c[OUT_W-1:0];
        if (d_reg == '0)
            z_c = '0;
        else if (root_reg == '0)
            z_c = d_reg[32] ? 16'sh8000 : 16'sh7FFF;
        else if (d_reg[32])
            z_c = 16'(~qc_c + 16'd1);
        else
            z_c = (qc_c == 16'h8000) ? 16'sh7FFF : 16'(qc_c);
        zmag_c = z_c[OUT_W-1] ? 16'(~z_c + 16'sd1) : 16'(z_c);
    end

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd)
            CMD_MEAN_MUL: begin mul_a = e_mag[31:0];  mul_b = {15'b0, alpha_a}; end
            CMD_SQ_MUL:   begin mul_a = dn_mag[31:0]; mul_b = dn_mag[31:0]; end
            CMD_VLO_MUL:  begin mul_a = {8'b0, diff_reg[23:0]};  mul_b = {15'b0, alpha_a}; end
            CMD_VHI_MUL:  begin mul_a = {8'b0, diff_reg[47:24]}; mul_b = {15'b0, alpha_a}; end
            CMD_SCALE:    begin mul_a = {17'b0, cfg.target_stddev}; mul_b = {16'b0, zmag_c}; end
            default:      mul_en = 1'b0;
        endcase
    end

    // final rescale and mean rounding
    always_comb
    begin
        sc_mag = 19'((prod_reg[30:0] + 31'h800) >> Z_FRAC);
        if (z_reg[OUT_W-1])
            sc_c = -$signed({2'b0, sc_mag}) + 21'(cfg.target_mean);
        else
            sc_c = $signed({2'b0, sc_mag}) + 21'(cfg.target_mean);
        mm_c = mean_reg[ACC_W-1] ? 33'(-{mean_reg[ACC_W-1], mean_reg})
                                 : 33'({mean_reg[ACC_W-1], mean_reg});
        mr_c = (mm_c + 33'h8000) >> MEAN_FRAC;
        rm_c = mean_reg[ACC_W-1] ? -$signed({4'b0, mr_c[16:0]}) : $signed({4'b0, mr_c[16:0]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg    <= '0;
            var_reg     <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            case (cmd)
                CMD_LOAD:
                begin
                    case (in_opcode)
                        OP_RESTART:
                        begin
                            started_reg <= 1'b0;
                            var_reg     <= '0;
                        end
                        OP_PRELOAD:
                        begin
                            mean_reg    <= {cfg.start_mean, {MEAN_FRAC{1'b0}}};
                            var_reg     <= {cfg.start_variance, 16'b0};
                            started_reg <= 1'b1;
                        end
                        OP_SAMPLE:
                        begin
                            if (!started_reg)
                            begin
                                mean_reg    <= {in_sample, {MEAN_FRAC{1'b0}}};
                                var_reg     <= '0;
                                started_reg <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_MEAN_UPD:
                    mean_reg <= eneg_reg ? mean_reg + $signed(m_inc[31:0])
                                         : mean_reg - $signed(m_inc[31:0]);
                CMD_VAR_UPD:
                    var_reg <= vneg_reg ? var_reg - v_inc : var_reg + v_inc;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= {32'b0, mul_a} * {32'b0, mul_b};
        case (cmd)
            CMD_LOAD:     x_reg <= in_sample;
            CMD_MEAN_MUL: eneg_reg <= e_c[32];
            CMD_VAR_DIFF:
            begin
                vneg_reg <= sq_c < var_reg;
                diff_reg <= (sq_c < var_reg) ? var_reg - sq_c : sq_c - var_reg;
            end
            CMD_VHI_MUL:  lo_reg <= prod_reg[40:0];
            CMD_SQRT_INIT:
            begin
                n_reg    <= {var_reg, 16'b0};
                srem_reg <= '0;
                root_reg <= '0;
                d_reg    <= dn_c;
            end
            CMD_SQRT_STEP:
            begin
                n_reg    <= {n_reg[59:0], 4'b0};
                srem_reg <= s2_c[66:32];
                root_reg <= s2_c[31:0];
            end
            CMD_DIV_INIT:
            begin
                drem_reg <= dnum_c;
                dv_reg   <= {root_reg, 16'b0};
                ovf_reg  <= {4'b0, dnum_c} >= {root_reg, 17'b0};
                q_reg    <= '0;
            end
            CMD_DIV_STEP:
            begin
                if (dge_c)
                    drem_reg <= drem_reg - dv_reg[44:0];
                q_reg  <= {q_reg[15:0], dge_c};
                dv_reg <= dv_reg >> 1;
            end
            CMD_SCALE:    z_reg <= z_c;
            CMD_FINISH:
            begin
                scaled_reg <= sat16(sc_c);
                zout_reg   <= z_reg;
                mout_reg   <= sat16(rm_c);
            end
            default: ;
        endcase
    end

    assign status.started = started_reg;
    assign scaled_value   = scaled_reg;
    assign z_score        = zout_reg;
    assign running_mean   = mout_reg;

endmodule

### hw/rtl/ezn_controller.sv
// ============================================================================
// ezn_controller
// Sequencer that steps the datapath through one sample's update.
// ============================================================================
`include "ema_zscore_normalizer_defines.svh"

module ezn_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_opcode,
    input  logic                out_ready,
    input  ezn_pkg::dp_status_t status,
    output ezn_pkg::cmd_t       cmd,
    output logic                in_ready,
    output logic                out_valid
);
    import ezn_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + CNT_W'(1);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_opcode == OP_SAMPLE)
                    state_next = status.started ? ST_MEAN_MUL : ST_SQRT_INIT;
            end
            ST_MEAN_MUL:  state_next = ST_MEAN_UPD;
            ST_MEAN_UPD:  state_next = ST_SQ_MUL;
            ST_SQ_MUL:    state_next = ST_VAR_DIFF;
            ST_VAR_DIFF:  state_next = ST_VLO_MUL;
            ST_VLO_MUL:   state_next = ST_VHI_MUL;
            ST_VHI_MUL:   state_next = ST_VAR_UPD;
            ST_VAR_UPD:   state_next = ST_SQRT_INIT;
            ST_SQRT_INIT:
            begin
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_SCALE;
            end
            ST_SCALE:     state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = CMD_NONE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd = CMD_LOAD;
            end
            ST_MEAN_MUL:  cmd = CMD_MEAN_MUL;
            ST_MEAN_UPD:  cmd = CMD_MEAN_UPD;
            ST_SQ_MUL:    cmd = CMD_SQ_MUL;
            ST_VAR_DIFF:  cmd = CMD_VAR_DIFF;
            ST_VLO_MUL:   cmd = CMD_VLO_MUL;
            ST_VHI_MUL:   cmd = CMD_VHI_MUL;
            ST_VAR_UPD:   cmd = CMD_VAR_UPD;
            ST_SQRT_INIT: cmd = CMD_SQRT_INIT;
            ST_SQRT:      cmd = CMD_SQRT_STEP;
            ST_DIV_INIT:  cmd = CMD_DIV_INIT;
            ST_DIV:       cmd = CMD_DIV_STEP;
            ST_SCALE:     cmd = CMD_SCALE;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd            = CMD_FINISH;
                    out_valid_next = 1'b1;
                end
            end
            default:      cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `EZN_ASSERT_SAME(a_finish_free, clk, rst_n, cmd == CMD_FINISH, out_free, "result overwritten")
    `EZN_ASSERT_NEXT(a_finish_valid, clk, rst_n, cmd == CMD_FINISH, out_valid_reg, "result lost")
    `EZN_ASSERT_NEXT(a_sample_busy, clk, rst_n, in_valid && in_ready && in_opcode == OP_SAMPLE, state_reg != ST_IDLE, "sample not started")
    `EZN_ASSERT_SAME(a_root_count, clk, rst_n, state_reg == ST_SQRT, cnt_reg < CNT_W'(SQRT_STEPS), "root count overrun")

endmodule

### hw/rtl/ema_zscore_normalizer.sv
// ============================================================================
// ema_zscore_normalizer
// Exponential moving mean/variance z-score normalizer, top level.
// ============================================================================
// Usage:
//   samples: valid/ready stream of {opcode, sample}. Opcode sample updates the
//   moving mean and variance and yields one transfer on results; restart and
//   preload yield nothing; opcode three is dropped.
//   results: valid/ready stream of {scaled_value, z_score, running_mean}.
//   cfg_we/cfg_index/cfg_data: register writes, to be made while idle.
// Sequence:
//   A sample runs from its transfer to a valid result through the mean and
//   variance updates (skipped for the first sample after restart), the
//   square root at two bits per cycle and the restoring divider at one bit
//   per cycle, with the shared 32x32 multiplier used in five passes. The
//   block takes no new sample until the result is valid, then is ready again.
// Reset:
//   rst_n clears the accumulators, the started flag and the sequencer, and
//   loads the register defaults. No clearing pass is needed.
// Stalls:
//   A result is held in an output register until taken; a next sample is
//   accepted meanwhile, and its result waits in the last step until the
//   output register is free.
// ============================================================================
module ema_zscore_normalizer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ezn_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ezn_pkg::CFG_DATA_W-1:0]  cfg_data,
    ezn_in_if.sink                          samples,
    ezn_out_if.source                       results
);
    import ezn_pkg::*;

    cfg_t       cfg;
    cmd_t       cmd;
    dp_status_t status;

    // register file
    ezn_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: owns the handshakes and issues one command per cycle
    ezn_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_opcode (samples.opcode),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (samples.ready),
        .out_valid (results.valid)
    );

    // arithmetic and the result register
    ezn_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg),
        .in_opcode    (samples.opcode),
        .in_sample    (samples.sample),
        .status       (status),
        .scaled_value (results.scaled_value),
        .z_score      (results.z_score),
        .running_mean (results.running_mean)
    );

endmodule

### tb/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the moving mean/variance z-score normalizer.
// ============================================================================
// A directed table opens the run: first samples after restart, extremes,
// equal samples, preload, and the ignored opcode. Random phases follow. Each
// phase writes a new register setting while the block is idle, then sends
// mostly sample streams around a drifting center, with restarts, preloads and
// ignored opcodes mixed in. A bit-accurate predictor runs on every accepted
// transfer and queues the expected result. A monitor compares each result
// transfer field by field. Idle rates of both sides change per phase.
// ============================================================================
module tb_top;
    import ezn_pkg::*;

    localparam logic [1:0]             OP_IGNORED    = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED    = 3'd5;
    localparam int                     DRAIN_CYCLES  = 60;
    localparam int                     STALL_LIMIT   = 20000;
    localparam int                     NUM_PHASES    = 9;
    localparam int                     PHASE_ITEMS   = 104;

    typedef struct {
        logic signed [OUT_W-1:0] scaled_value;
        logic signed [OUT_W-1:0] z_score;
        logic signed [OUT_W-1:0] running_mean;
    } norm_result_t;

    typedef struct packed {
        logic [1:0]                 op;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       typed;
        logic signed [OUT_W-1:0]    scaled_value;
        logic signed [OUT_W-1:0]    z_score;
        logic signed [OUT_W-1:0]    running_mean;
    } directed_row_t;

    // Typed rows assume the reset setting (target mean one half).
    localparam directed_row_t DIRECTED_ROWS [0:13] = '{
        '{OP_RESTART, 16'sd0,      1'b0, 16'sd0,     16'sd0, 16'sd0},
        '{OP_SAMPLE,  16'sd32767,  1'b1, 16'sd16384, 16'sd0, 16'sd32767},
        '{OP_SAMPLE,  -16'sd32768, 1'b0, 16'sd0,     16'sd0, 16'sd0},
        '{OP_SAMPLE,  16'sd0,      1'b0, 16'sd0,     16'sd0, 16'sd0},
        '{OP_IGNORED, 16'sd1234,   1'b0, 16'sd0,     16'sd0, 16'sd0},
        '{OP_SAMPLE,  -16'sd1,     1'b0, 16'sd0,     16'sd0, 16'sd0},
        '{OP_RESTART, 16'sd0,      1'b0, 16'sd0,     16'sd0, 16'sd0},
        '{OP_SAMPLE,  -16'sd32768, 1'b1, 16'sd16384, 16'sd0, -16'sd32768},
        '{OP_SAMPLE,  -16'sd32768, 1'b1, 16'sd16384, 16'sd0, -16'sd32768},
        '{OP_SAMPLE,  16'sd32767,  1'b0, 16'sd0,     16'sd0, 16'sd0},
        '{OP_PRELOAD, 16'sd0,      1'b0, 16'sd0,     16'sd0, 16'sd0},
        '{OP_SAMPLE,  16'sd0,      1'b1, 16'sd16384, 16'sd0, 16'sd0},
        '{OP_SAMPLE,  16'sd1,      1'b0, 16'sd0,     16'sd0, 16'sd0},
        '{OP_SAMPLE,  16'sd32767,  1'b0, 16'sd0,     16'sd0, 16'sd0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ezn_in_if  samples ();
    ezn_out_if results ();

    ema_zscore_normalizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples.sink),
        .results   (results.source)
    );

    // Shadow copy of the registers and filter state.
    logic [ALPHA_W-1:0]         sh_alpha;
    logic signed [OUT_W-1:0]    sh_tmean;
    logic [TSTD_W-1:0]          sh_tstd;
    logic signed [SAMPLE_W-1:0] sh_smean;
    logic [SVAR_W-1:0]          sh_svar;
    longint                     mean_acc;
    longint unsigned            var_acc;
    bit                         started;

    norm_result_t expected_q[$];
    int           errors;
    int           sender_idle_pct;
    int           receiver_idle_pct;
    int           idle_cycles;

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? 64'd0 - longint'(v) : longint'(v);
    endfunction

    function automatic longint unsigned scale_by_alpha(longint unsigned v,
                                                       longint unsigned a);
        return (v * a + (64'd1 << (ALPHA_FRAC - 1))) >> ALPHA_FRAC;
    endfunction

    function automatic longint round_shift(longint v, int sh);
        longint unsigned m;
        m = (magnitude(v) + (64'd1 << (sh - 1))) >> sh;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp16(longint v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Advance the shadow filter by one accepted transfer; report a result
    // only for samples.
    function automatic bit normalize_step(logic [1:0] op,
                                          logic signed [SAMPLE_W-1:0] smp,
                                          output norm_result_t res);
        longint unsigned a;
        longint unsigned m;
        longint unsigned sq;
        longint unsigned s;
        longint unsigned q;
        longint          x;
        longint          e;
        longint          d;
        longint          z;
        a = sh_alpha > ALPHA_ONE ? ALPHA_ONE : sh_alpha;
        res = '{0, 0, 0};
        if (op == OP_RESTART)
        begin
            started = 0;
            var_acc = 0;
            return 0;
        end
        if (op == OP_PRELOAD)
        begin
            mean_acc = longint'(sh_smean) * 65536;
            var_acc  = (longint'(sh_svar) << MEAN_FRAC) & 64'hFFFF_FFFF_FFFF;
            started  = 1;
            return 0;
        end
        if (op != OP_SAMPLE)
            return 0;
        x = longint'(smp) * 65536;
        if (!started)
        begin
            mean_acc = x;
            var_acc  = 0;
            started  = 1;
        end
        else
        begin
            e = mean_acc - x;
            m = scale_by_alpha(magnitude(e), a);
            mean_acc = e < 0 ? mean_acc + longint'(m) : mean_acc - longint'(m);
            d  = x - mean_acc;
            sq = (magnitude(d) * magnitude(d) + 64'd32768) >> 16;
            if (sq >= var_acc)
                var_acc += scale_by_alpha(sq - var_acc, a);
            else
                var_acc -= scale_by_alpha(var_acc - sq, a);
            var_acc &= 64'hFFFF_FFFF_FFFF;
        end
        d = x - mean_acc;
        s = int_sqrt(var_acc << 16);
        if (d == 0)
            z = 0;
        else if (s == 0)
            z = d < 0 ? -32768 : 32767;
        else
        begin
            q = ((magnitude(d) << 13) / s + 1) >> 1;
            if (q > 32768)
                q = 32768;
            z = clamp16(d < 0 ? -longint'(q) : longint'(q));
        end
        res.z_score      = z[15:0];
        res.scaled_value = OUT_W'(clamp16(round_shift(longint'(sh_tstd) * z, Z_FRAC)
                                          + longint'(sh_tmean)));
        res.running_mean = OUT_W'(clamp16(round_shift(mean_acc, MEAN_FRAC)));
        return 1;
    endfunction

    initial
    begin
        clk = 0;
        forever
            #2 clk = ~clk;
    end

    // Receiver: decide ready at each falling edge.
    always @(negedge clk)
        results.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);

    // Monitor: compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        norm_result_t exp_r;
        if (rst_n && results.valid && results.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result transfer with no expectation pending");
                errors++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (results.scaled_value !== exp_r.scaled_value)
                begin
                    $error("scaled_value: expected %0d, actual %0d",
                           exp_r.scaled_value, results.scaled_value);
                    errors++;
                end
                if (results.z_score !== exp_r.z_score)
                begin
                    $error("z_score: expected %0d, actual %0d",
                           exp_r.z_score, results.z_score);
                    errors++;
                end
                if (results.running_mean !== exp_r.running_mean)
                begin
                    $error("running_mean: expected %0d, actual %0d",
                           exp_r.running_mean, results.running_mean);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((samples.valid && samples.ready) || (results.valid && results.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Write one register and mirror the write into the shadow copy.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 0;
        case (idx)
            CFG_ALPHA: sh_alpha = val[ALPHA_W-1:0];
            CFG_TMEAN: sh_tmean = val[OUT_W-1:0];
            CFG_TSTD:  sh_tstd  = val[TSTD_W-1:0];
            CFG_SMEAN: sh_smean = val[SAMPLE_W-1:0];
            CFG_SVAR:  sh_svar  = val[SVAR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Present one item at the falling edge and hold it until the transfer.
    // Each cycle the sender idles with the current idle rate.
    task automatic send_item(logic [1:0] op, logic signed [SAMPLE_W-1:0] smp,
                             bit typed, norm_result_t typed_res);
        norm_result_t res;
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            samples.valid = 0;
            @(negedge clk);
        end
        samples.valid  = 1;
        samples.opcode = op;
        samples.sample = smp;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        if (normalize_step(op, smp, res))
            expected_q.push_back(typed ? typed_res : res);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(int center, int spread);
        int v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 1) ? 32767 : -32768;
            1, 2: v = $signed($urandom_range(0, 65535)) - 32768;
            default: v = center + $signed($urandom_range(0, 2 * spread)) - spread;
        endcase
        return SAMPLE_W'(clamp16(v));
    endfunction

    initial
    begin
        norm_result_t tr;
        int           center;
        int           spread;
        int           pick;
        logic [1:0]   op;
        errors            = 0;
        idle_cycles       = 0;
        sender_idle_pct   = 7;
        receiver_idle_pct = 88;
        cfg_we            = 0;
        cfg_index         = CFG_ALPHA;
        cfg_data          = '0;
        samples.valid     = 0;
        samples.opcode    = OP_SAMPLE;
        samples.sample    = '0;
        results.ready     = 0;
        sh_alpha = ALPHA_RESET;
        sh_tmean = TMEAN_RESET;
        sh_tstd  = TSTD_RESET;
        sh_smean = SMEAN_RESET;
        sh_svar  = SVAR_RESET;
        mean_acc = 0;
        var_acc  = 0;
        started  = 0;
        rst_n    = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed table under the reset setting.
        foreach (DIRECTED_ROWS[i])
        begin
            tr = '{DIRECTED_ROWS[i].scaled_value, DIRECTED_ROWS[i].z_score,
                   DIRECTED_ROWS[i].running_mean};
            send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].sample,
                      DIRECTED_ROWS[i].typed, tr);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            @(negedge clk);
            samples.valid = 0;
            wait_drained();
            // Fixed extremes first, random settings after.
            case (ph)
                0:
                begin
                    // Alpha zero freezes the filter: full scale, nonzero deviation.
                    write_reg(CFG_ALPHA, 0);
                    write_reg(CFG_TMEAN, 32'hFFFF_8000);
                    write_reg(CFG_TSTD, 32767);
                    write_reg(CFG_SMEAN, 32767);
                    write_reg(CFG_SVAR, 0);
                end
                1:
                begin
                    // Alpha above one acts as one.
                    write_reg(CFG_ALPHA, 131071);
                    write_reg(CFG_TMEAN, 32767);
                    write_reg(CFG_TSTD, 0);
                    write_reg(CFG_SMEAN, 32'hFFFF_8000);
                    write_reg(CFG_SVAR, 32'hFFFF_FFFF);
                end
                2:
                begin
                    write_reg(CFG_ALPHA, ALPHA_ONE);
                    write_reg(CFG_TMEAN, 0);
                    write_reg(CFG_TSTD, 32767);
                    write_reg(CFG_SVAR, 1);
                    write_reg(CFG_UNUSED, $urandom);
                end
                default:
                begin
                    write_reg(CFG_ALPHA, $urandom_range(0, 3) == 0 ?
                              $urandom_range(0, 131071) : $urandom_range(1, 20000));
                    write_reg(CFG_TMEAN, $urandom);
                    write_reg(CFG_TSTD, $urandom);
                    write_reg(CFG_SMEAN, $urandom);
                    write_reg(CFG_SVAR, $urandom_range(0, 3) == 0 ?
                              $urandom : $urandom_range(0, 1 << 20));
                end
            endcase
            case (ph % 3)
                0:
                begin
                    sender_idle_pct   = 7;
                    receiver_idle_pct = 88;
                end
                1:
                begin
                    sender_idle_pct   = 88;
                    receiver_idle_pct = 7;
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            center = $signed($urandom_range(0, 65535)) - 32768;
            spread = 1 << $urandom_range(0, 12);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Hold off midway until the pipeline is empty.
                if (n == PHASE_ITEMS / 2)
                begin
                    @(negedge clk);
                    samples.valid = 0;
                    while (expected_q.size() != 0)
                        @(posedge clk);
                end
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    op = OP_RESTART;
                else if (pick < 8)
                    op = OP_PRELOAD;
                else if (pick < 10)
                    op = OP_IGNORED;
                else
                    op = OP_SAMPLE;
                if ($urandom_range(0, 49) == 0)
                    center = $signed($urandom_range(0, 65535)) - 32768;
                send_item(op, pick_sample(center, spread), 0, tr);
            end
        end

        @(negedge clk);
        samples.valid = 0;
        wait_drained();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

### ema_zscore_normalizer.f
+incdir+hw/rtl
hw/rtl/ezn_pkg.sv
hw/rtl/ezn_if.sv
hw/rtl/ezn_cfg_regs.sv
hw/rtl/ezn_datapath.sv
hw/rtl/ezn_controller.sv
hw/rtl/ema_zscore_normalizer.sv
tb/tb_top.sv
